[rtl/core/obdf_pkg.sv]
// shared constants, types and state encodings for the oar blade drive force block
package obdf_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int HORNER_STEPS  = 6;
	localparam int HSTEP_W       = 3;
	localparam int CFG_IDX_W     = 1;

	localparam logic [30:0] ONE30          = 31'h4000_0000;
	localparam logic [29:0] HALF30         = 30'h2000_0000;
	localparam logic [31:0] THREE30        = 32'hC000_0000;
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
	localparam logic [32:0] TWO_PI_Q30     = 33'd6746518852;
	localparam logic [31:0] PI_Q30         = 32'd3373259426;
	localparam logic [34:0] THIRTEEN30     = 35'd13958643712;

	// reciprocals for exact floor division by small constants
	localparam logic [33:0] RECIP_3 = 34'(((64'd1 << 34) + 64'd2) / 64'd3);
	localparam logic [33:0] RECIP_5 = 34'(((64'd1 << 36) + 64'd4) / 64'd5);

	localparam logic [33:0] HORNER_M [HORNER_STEPS] = '{
		34'(((64'd1 << 40) + 64'd131) / 64'd132),
		34'(((64'd1 << 39) + 64'd89) / 64'd90),
		34'(((64'd1 << 38) + 64'd55) / 64'd56),
		34'(((64'd1 << 37) + 64'd29) / 64'd30),
		34'(((64'd1 << 36) + 64'd11) / 64'd12),
		34'(((64'd1 << 33) + 64'd1) / 64'd2)
	};
	localparam int HORNER_N [HORNER_STEPS] = '{40, 39, 38, 37, 36, 33};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLADE_GAIN = 1'b0,
		REG_FULL_DEPTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		P_IDLE,
		P_SQ,
		P_MUL,
		P_DIV
	} poly_state_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_N,
		PH_X,
		PH_WAIT,
		PH_H
	} phase_state_t;

	typedef enum logic [3:0] {
		L_IDLE,
		L_TURN,
		L_X,
		L_DIV,
		L_R2,
		L_S,
		L_WAIT,
		L_SC,
		L_M,
		L_V,
		L_G
	} lane_state_t;

	typedef struct packed {
		logic        start;
		logic [30:0] x;
	} poly_req_t;

	typedef struct packed {
		logic        done;
		logic [30:0] p;
	} poly_rsp_t;

	typedef struct packed {
		logic        valid;
		logic [30:0] h;
	} shape_t;

	typedef struct packed {
		logic [31:0] gain;
		logic [31:0] full;
	} lane_cfg_t;

endpackage

[rtl/core/obdf_poly.sv]
// cosine polynomial sequencer: one multiplier, six horner steps
module obdf_poly (
	input  logic                clk,
	input  logic                arst_n,
	input  obdf_pkg::poly_req_t req,
	output obdf_pkg::poly_rsp_t rsp
);

	obdf_pkg::poly_state_t state_q, state_d;

	logic [30:0]                  x_q;
	logic [31:0]                  x2_q;
	logic [31:0]                  t_q;
	logic [30:0]                  p_q;
	logic [obdf_pkg::HSTEP_W-1:0] k_q;
	logic                         done_q;
	logic [33:0]                  mul_a, mul_b;
	logic [67:0]                  prod;
	logic [67:0]                  q_wide;
	logic [31:0]                  q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			obdf_pkg::P_IDLE: if (req.start) state_d = obdf_pkg::P_SQ;
			obdf_pkg::P_SQ:   state_d = obdf_pkg::P_MUL;
			obdf_pkg::P_MUL:  state_d = obdf_pkg::P_DIV;
			obdf_pkg::P_DIV: begin
				if (k_q == obdf_pkg::HSTEP_W'(obdf_pkg::HORNER_STEPS - 1))
					state_d = obdf_pkg::P_IDLE;
				else
					state_d = obdf_pkg::P_MUL;
			end
			default: state_d = obdf_pkg::P_IDLE;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			obdf_pkg::P_SQ: begin
				mul_a = {3'b0, x_q};
				mul_b = {3'b0, x_q};
			end
			obdf_pkg::P_MUL: begin
				mul_a = {2'b0, x2_q};
				mul_b = {3'b0, p_q};
			end
			obdf_pkg::P_DIV: begin
				mul_a = {2'b0, t_q};
				mul_b = obdf_pkg::HORNER_M[k_q];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod   = mul_a * mul_b;
	assign q_wide = prod >> obdf_pkg::HORNER_N[k_q];
	assign q      = q_wide[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= obdf_pkg::P_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == obdf_pkg::P_DIV) &&
				(k_q == obdf_pkg::HSTEP_W'(obdf_pkg::HORNER_STEPS - 1));
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			obdf_pkg::P_IDLE: begin
				if (req.start) begin
					x_q <= req.x;
					p_q <= obdf_pkg::ONE30;
					k_q <= '0;
				end
			end
			obdf_pkg::P_SQ:  x2_q <= prod[61:30];
			obdf_pkg::P_MUL: t_q <= prod[61:30];
			obdf_pkg::P_DIV: begin
				p_q <= (q >= {1'b0, obdf_pkg::ONE30}) ? '0 : obdf_pkg::ONE30 - q[30:0];
				k_q <= k_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.p    = p_q;

endmodule

[rtl/core/obdf_phase.sv]
// stroke phase shape unit: 0.65 + 0.35 sin(pi clamp(t / 0.48))
module obdf_phase #(
	parameter int FRAC_BITS = obdf_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [30:0]      phase_time,
	output obdf_pkg::shape_t shape
);

	localparam logic [35:0] LIM = 36'(12) << FRAC_BITS;

	obdf_pkg::phase_state_t state_q, state_d;
	obdf_pkg::poly_req_t    preq;
	obdf_pkg::poly_rsp_t    prsp;

	logic [30:0] pt_q;
	logic [30:0] n_q;
	logic [32:0] num4_q;
	logic [30:0] h_q;
	logic        valid_q;
	logic [35:0] pt25;
	logic        sat;
	logic [63:0] scaled;
	logic [31:0] a4;
	logic [29:0] half_off;
	logic [34:0] num;
	logic [33:0] mul_a, mul_b;
	logic [67:0] prod;

	assign pt25     = ({5'b0, pt_q} << 4) + ({5'b0, pt_q} << 3) + {5'b0, pt_q};
	assign sat      = pt25 >= LIM;
	assign scaled   = {28'b0, pt25} << (30 - FRAC_BITS);
	assign a4       = scaled[33:2];
	assign half_off = (n_q >= {1'b0, obdf_pkg::HALF30}) ?
		30'(n_q - {1'b0, obdf_pkg::HALF30}) : 30'({1'b0, obdf_pkg::HALF30} - n_q);
	assign num      = obdf_pkg::THIRTEEN30 + 35'({4'b0, prsp.p} * 35'd7);

	always_comb begin
		state_d = state_q;
		case (state_q)
			obdf_pkg::PH_IDLE: if (start) state_d = obdf_pkg::PH_N;
			obdf_pkg::PH_N:    state_d = obdf_pkg::PH_X;
			obdf_pkg::PH_X:    state_d = obdf_pkg::PH_WAIT;
			obdf_pkg::PH_WAIT: if (prsp.done) state_d = obdf_pkg::PH_H;
			obdf_pkg::PH_H:    state_d = obdf_pkg::PH_IDLE;
			default:           state_d = obdf_pkg::PH_IDLE;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			obdf_pkg::PH_N: begin
				mul_a = {2'b0, a4};
				mul_b = obdf_pkg::RECIP_3;
			end
			obdf_pkg::PH_X: begin
				mul_a = {4'b0, half_off};
				mul_b = {2'b0, obdf_pkg::PI_Q30};
			end
			obdf_pkg::PH_H: begin
				mul_a = {1'b0, num4_q};
				mul_b = obdf_pkg::RECIP_5;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod       = mul_a * mul_b;
	assign preq.start = (state_q == obdf_pkg::PH_X);
	assign preq.x     = prod[60:30];

	obdf_poly u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (preq),
		.rsp    (prsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= obdf_pkg::PH_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start)
				valid_q <= 1'b0;
			else if (state_q == obdf_pkg::PH_H)
				valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			obdf_pkg::PH_IDLE: if (start) pt_q <= phase_time;
			obdf_pkg::PH_N:    n_q <= sat ? obdf_pkg::ONE30 : prod[64:34];
			obdf_pkg::PH_WAIT: if (prsp.done) num4_q <= num[34:2];
			obdf_pkg::PH_H:    h_q <= prod[66:36];
			default: ;
		endcase
	end

	assign shape.valid = valid_q;
	assign shape.h     = h_q;

endmodule

[rtl/core/obdf_lane.sv]
// one oar lane: immersion ratio divider, alignment cosine and force product chain
module obdf_lane #(
	parameter int FRAC_BITS = obdf_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         depth,
	input  logic [31:0]         angle,
	input  logic [31:0]         tip_speed,
	input  obdf_pkg::lane_cfg_t cfg,
	input  obdf_pkg::shape_t    shape,
	output logic                done,
	output logic [31:0]         force_out
);

	localparam int DIV_STEPS = 30;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	obdf_pkg::lane_state_t state_q, state_d;
	obdf_pkg::poly_req_t   preq;
	obdf_pkg::poly_rsp_t   prsp;

	logic [31:0]      ang_mag_q, tip_mag_q, gain_mag_q;
	logic             gain_neg_q;
	logic             r_zero_q, r_one_q;
	logic [30:0]      full_q;
	logic [30:0]      rem_q;
	logic [29:0]      quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [29:0]      u_q;
	logic             czero_q;
	logic [30:0]      c_q;
	logic             c_valid_q;
	logic [30:0]      r_q;
	logic [31:0]      w_q;
	logic [31:0]      force_q;
	logic             done_q;
	logic [33:0]      mul_a, mul_b;
	logic [67:0]      prod;
	logic [31:0]      turns;
	logic [32:0]      fold;
	logic [31:0]      shifted;
	logic             ge;
	logic [30:0]      r_sel;
	logic [63:0]      mag;
	logic [31:0]      sat_val;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		mag32 = v[31] ? 32'(-v) : v;
	endfunction

	assign turns   = prod[FRAC_BITS+31:FRAC_BITS];
	assign fold    = turns[31] ? 33'h1_0000_0000 - {1'b0, turns} : {1'b0, turns};
	assign shifted = {rem_q, 1'b0};
	assign ge      = shifted >= {1'b0, full_q};
	assign r_sel   = r_zero_q ? '0 : (r_one_q ? obdf_pkg::ONE30 : {1'b0, quo_q});
	assign mag     = prod[63:0] >> FRAC_BITS;

	always_comb begin
		if (!gain_neg_q)
			sat_val = (|mag[63:31]) ? 32'h7FFF_FFFF : mag[31:0];
		else if ((|mag[63:32]) || (mag[31] && (|mag[30:0])))
			sat_val = 32'h8000_0000;
		else
			sat_val = 32'(-mag[31:0]);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			obdf_pkg::L_IDLE: if (start) state_d = obdf_pkg::L_TURN;
			obdf_pkg::L_TURN: state_d = obdf_pkg::L_X;
			obdf_pkg::L_X:    state_d = obdf_pkg::L_DIV;
			obdf_pkg::L_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = obdf_pkg::L_R2;
			end
			obdf_pkg::L_R2:   state_d = obdf_pkg::L_S;
			obdf_pkg::L_S:    state_d = obdf_pkg::L_WAIT;
			obdf_pkg::L_WAIT: if (c_valid_q && shape.valid) state_d = obdf_pkg::L_SC;
			obdf_pkg::L_SC:   state_d = obdf_pkg::L_M;
			obdf_pkg::L_M:    state_d = obdf_pkg::L_V;
			obdf_pkg::L_V:    state_d = obdf_pkg::L_G;
			obdf_pkg::L_G:    state_d = obdf_pkg::L_IDLE;
			default:          state_d = obdf_pkg::L_IDLE;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			obdf_pkg::L_TURN: begin
				mul_a = {2'b0, ang_mag_q};
				mul_b = {4'b0, obdf_pkg::INV_TWO_PI_Q32};
			end
			obdf_pkg::L_X: begin
				mul_a = {4'b0, u_q};
				mul_b = {1'b0, obdf_pkg::TWO_PI_Q30};
			end
			obdf_pkg::L_R2: begin
				mul_a = {3'b0, r_sel};
				mul_b = {3'b0, r_sel};
			end
			obdf_pkg::L_S: begin
				mul_a = {2'b0, w_q};
				mul_b = {2'b0, obdf_pkg::THREE30 - {r_q, 1'b0}};
			end
			obdf_pkg::L_SC: begin
				mul_a = {2'b0, w_q};
				mul_b = {3'b0, c_q};
			end
			obdf_pkg::L_M: begin
				mul_a = {2'b0, w_q};
				mul_b = {3'b0, shape.h};
			end
			obdf_pkg::L_V: begin
				mul_a = {2'b0, tip_mag_q};
				mul_b = {2'b0, w_q};
			end
			obdf_pkg::L_G: begin
				mul_a = {2'b0, gain_mag_q};
				mul_b = {2'b0, w_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod       = mul_a * mul_b;
	assign preq.start = (state_q == obdf_pkg::L_X);
	assign preq.x     = prod[62:32];

	obdf_poly u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (preq),
		.rsp    (prsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= obdf_pkg::L_IDLE;
			done_q    <= 1'b0;
			c_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == obdf_pkg::L_G);
			if (start && state_q == obdf_pkg::L_IDLE)
				c_valid_q <= 1'b0;
			else if (prsp.done)
				c_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (prsp.done)
			c_q <= czero_q ? '0 : prsp.p;
		case (state_q)
			obdf_pkg::L_IDLE: begin
				if (start) begin
					ang_mag_q  <= mag32(angle);
					tip_mag_q  <= mag32(tip_speed);
					gain_mag_q <= mag32(cfg.gain);
					gain_neg_q <= cfg.gain[31];
					full_q     <= cfg.full[30:0];
					r_zero_q   <= cfg.full[31] || (cfg.full == '0) ||
						depth[31] || (depth == '0);
					r_one_q    <= $signed(depth) >= $signed(cfg.full);
					rem_q      <= depth[30:0];
					quo_q      <= '0;
					cnt_q      <= '0;
				end
			end
			obdf_pkg::L_TURN: begin
				u_q     <= fold[29:0];
				czero_q <= fold >= {2'b0, obdf_pkg::ONE30};
			end
			obdf_pkg::L_DIV: begin
				// one quotient bit per cycle
				rem_q <= ge ? 31'(shifted - {1'b0, full_q}) : shifted[30:0];
				quo_q <= {quo_q[28:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			obdf_pkg::L_R2: begin
				r_q <= r_sel;
				w_q <= prod[61:30];
			end
			obdf_pkg::L_S:  w_q <= {1'b0, prod[60:30]};
			obdf_pkg::L_SC: w_q <= {1'b0, prod[60:30]};
			obdf_pkg::L_M:  w_q <= {1'b0, prod[60:30]};
			obdf_pkg::L_V:  w_q <= prod[61:30];
			obdf_pkg::L_G:  force_q <= sat_val;
			default: ;
		endcase
	end

	assign done      = done_q;
	assign force_out = force_q;

endmodule

[rtl/core/oar_blade_drive_force_top.sv]
// oar blade drive force: top level with input stage, two oar lanes, phase unit and merge
//
// channel   direction  transaction carries
// s_axis    in         one stroke sample (drive flag in tuser, phase and oar fields in tdata)
// m_axis    out        forces and passed-through depths for both oars
// cfg       in         register index and write data (blade gain, full depth)
//
// a sample in drive passes from the input register through the lanes to the output
// register, each lane holding a 30-step radix-2 immersion ratio divider
// a sample outside drive skips the lanes on its way to the output register
// the input register takes the next transaction while a sample is at work, and the
// output register holds a finished result while the lanes start on the next one
// reset clears the handshake state and both configuration registers to zero
module oar_blade_drive_force_top #(
	parameter int FRAC_BITS = obdf_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [30:0] phase_time, [62:31] port_depth, [94:63] port_angle,
	// [126:95] port_tip_speed, [158:127] stbd_depth, [190:159] stbd_angle,
	// [222:191] stbd_tip_speed, [223] zero
	input  logic [223:0]                   s_axis_tdata,
	// [0] in_drive
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [31:0] port_force, [63:32] stbd_force, [95:64] port_depth_out,
	// [127:96] stbd_depth_out
	output logic [127:0]                   m_axis_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [obdf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	logic [31:0] gain_q, full_q;

	// input register
	logic [222:0] in_data_q;
	logic         in_drive_q;
	logic         in_valid_q;

	// engine control
	logic         run_q, drive_q;
	logic [1:0]   ldone_q;
	logic [31:0]  port_depth_q, stbd_depth_q;
	logic         start, lane_start, pend, out_load;

	// output register
	logic [127:0] out_q;
	logic         out_valid_q;

	obdf_pkg::lane_cfg_t lcfg;
	obdf_pkg::shape_t    shape;
	logic                port_done, stbd_done;
	logic [31:0]         port_force, stbd_force;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			full_q <= '0;
		end else if (cfg_valid) begin
			case (obdf_pkg::cfg_reg_t'(cfg_index))
				obdf_pkg::REG_BLADE_GAIN: gain_q <= cfg_data;
				obdf_pkg::REG_FULL_DEPTH: full_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign lcfg.gain = gain_q;
	assign lcfg.full = full_q;

	// engine takes the held sample once the previous one has gone to the output register
	assign s_axis_tready = !in_valid_q;
	assign start         = in_valid_q && !run_q;
	assign lane_start    = start && in_drive_q;
	assign pend          = run_q && (!drive_q || (&ldone_q));
	assign out_load      = pend && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q  <= 1'b0;
			run_q       <= 1'b0;
			drive_q     <= 1'b0;
			ldone_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				in_valid_q <= 1'b1;
			else if (start)
				in_valid_q <= 1'b0;

			if (start) begin
				run_q   <= 1'b1;
				drive_q <= in_drive_q;
				ldone_q <= '0;
			end else begin
				if (out_load)
					run_q <= 1'b0;
				if (port_done)
					ldone_q[0] <= 1'b1;
				if (stbd_done)
					ldone_q[1] <= 1'b1;
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_data_q  <= s_axis_tdata[222:0];
			in_drive_q <= s_axis_tuser;
		end
		if (start) begin
			port_depth_q <= in_data_q[62:31];
			stbd_depth_q <= in_data_q[158:127];
		end
		// merge: both lane results and the depths, or all zero outside drive
		if (out_load)
			out_q <= drive_q ? {stbd_depth_q, port_depth_q, stbd_force, port_force} : '0;
	end

	obdf_phase #(
		.FRAC_BITS (FRAC_BITS)
	) u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (lane_start),
		.phase_time (in_data_q[30:0]),
		.shape      (shape)
	);

	obdf_lane #(
		.FRAC_BITS (FRAC_BITS)
	) u_lane_port (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (lane_start),
		.depth     (in_data_q[62:31]),
		.angle     (in_data_q[94:63]),
		.tip_speed (in_data_q[126:95]),
		.cfg       (lcfg),
		.shape     (shape),
		.done      (port_done),
		.force_out (port_force)
	);

	obdf_lane #(
		.FRAC_BITS (FRAC_BITS)
	) u_lane_stbd (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (lane_start),
		.depth     (in_data_q[158:127]),
		.angle     (in_data_q[190:159]),
		.tip_speed (in_data_q[222:191]),
		.cfg       (lcfg),
		.shape     (shape),
		.done      (stbd_done),
		.force_out (stbd_force)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule
